### rtl/uri_percent_decoder_macros.svh
// Assertion macros for the percent decoder.
// Each check runs on the rising edge of clk and is held off while rst_n is low.
`ifndef URI_PERCENT_DECODER_MACROS_SVH
`define URI_PERCENT_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define UPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define UPD_ASSERT_NOW(label, ante, cons, msg)
`define UPD_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### rtl/upd_pkg.sv
`timescale 1ns / 1ps

package upd_pkg;

  // Escape tracking within one header value.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PCT  = 2'd1,
    PH_DIG  = 2'd2
  } phase_t;

  localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CH_QUERY = 8'h3F;  // '?'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_UPA   = 8'h41;  // 'A'
  localparam logic [7:0] CH_LOA   = 8'h61;  // 'a'
  localparam logic [7:0] HEX_TEN  = 8'd10;

  localparam int MAX_RES = 3;

  // Queue between the classifier and the result stage.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // All results caused by one input byte.
  typedef struct packed {
    logic [1:0]              cnt;    // number of results, 1 to 3
    logic [MAX_RES-1:0][7:0] bytes;  // result bytes, slot 0 first
    logic                    bare;   // single end marker without a byte
    logic                    last;   // final slot closes the value
  } bundle_t;

  // Front state made visible for checking.
  typedef struct packed {
    phase_t phase;
    logic   query_seen;
  } front_stat_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  function automatic logic [3:0] nibble(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c inside {[8'h30:8'h39]}) begin
      v = c - CH_ZERO;
    end else if (c inside {[8'h41:8'h46]}) begin
      v = c - CH_UPA + HEX_TEN;
    end else if (c inside {[8'h61:8'h66]}) begin
      v = c - CH_LOA + HEX_TEN;
    end
    nibble = v[3:0];
  endfunction

endpackage

### rtl/upd_front.sv
`timescale 1ns / 1ps

module upd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  input  logic [7:0]       in_value_byte,
  input  logic             in_end_of_value,
  input  logic             q_full,
  output logic             q_push,
  output upd_pkg::bundle_t q_data,
  output upd_pkg::front_stat_t stat
);

  upd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]      held_r, held_nxt;
  logic            query_r, query_nxt;

  logic                              accept;
  logic [1:0]                        n;
  logic [upd_pkg::MAX_RES-1:0][7:0]  bytes;
  logic                              bare;
  logic                              b_hex;
  logic                              plain;
  logic                              pend_pct;
  logic                              pend_dig;

  assign accept = in_push && !q_full;
  assign b_hex  = upd_pkg::is_hex(in_value_byte);

  // A byte that is not consumed by an escape is handled as a plain byte.
  assign plain = !query_r &&
                 (!b_hex || (phase_r != upd_pkg::PH_PCT && phase_r != upd_pkg::PH_DIG));

  // Escape still pending once this byte has been taken in.
  assign pend_pct = plain && (in_value_byte == upd_pkg::CH_PCT);
  assign pend_dig = !query_r && (phase_r == upd_pkg::PH_PCT) && b_hex;

  // Next escape state; the end of the value returns everything to idle.
  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    query_nxt = query_r;

    if (!query_r) begin
      case (phase_r)
        upd_pkg::PH_PCT: begin
          if (b_hex) begin
            held_nxt  = in_value_byte;
            phase_nxt = upd_pkg::PH_DIG;
          end else begin
            phase_nxt = upd_pkg::PH_IDLE;
          end
        end
        upd_pkg::PH_DIG: begin
          phase_nxt = upd_pkg::PH_IDLE;
          held_nxt  = 8'd0;
        end
        default: begin
          phase_nxt = upd_pkg::PH_IDLE;
        end
      endcase

      if (plain) begin
        if (in_value_byte == upd_pkg::CH_QUERY) begin
          query_nxt = 1'b1;
        end else if (in_value_byte == upd_pkg::CH_PCT) begin
          phase_nxt = upd_pkg::PH_PCT;
        end
      end
    end

    if (in_end_of_value) begin
      phase_nxt = upd_pkg::PH_IDLE;
      held_nxt  = 8'd0;
      query_nxt = 1'b0;
    end
  end

  // Collect the results of the byte, then flush a pending escape at the end.
  always_comb begin
    n     = 2'd0;
    bytes = '0;
    bare  = 1'b0;

    if (!query_r) begin
      case (phase_r)
        upd_pkg::PH_PCT: begin
          if (!b_hex) begin
            bytes[n] = upd_pkg::CH_PCT;
            n        = n + 2'd1;
          end
        end
        upd_pkg::PH_DIG: begin
          if (b_hex) begin
            bytes[n] = {upd_pkg::nibble(held_r), upd_pkg::nibble(in_value_byte)};
            n        = n + 2'd1;
          end else begin
            bytes[n] = upd_pkg::CH_PCT;
            n        = n + 2'd1;
            bytes[n] = held_r;
            n        = n + 2'd1;
          end
        end
        default: begin
        end
      endcase

      if (plain && in_value_byte != upd_pkg::CH_QUERY &&
          in_value_byte != upd_pkg::CH_PCT) begin
        bytes[n] = in_value_byte;
        n        = n + 2'd1;
      end
    end

    if (in_end_of_value) begin
      if (pend_pct) begin
        bytes[n] = upd_pkg::CH_PCT;
        n        = n + 2'd1;
      end else if (pend_dig) begin
        bytes[n] = upd_pkg::CH_PCT;
        n        = n + 2'd1;
        bytes[n] = in_value_byte;
        n        = n + 2'd1;
      end
      if (n == 2'd0) begin
        bare = 1'b1;
        n    = 2'd1;
      end
    end
  end

  // Hand a request to the queue only when it carries at least one result.
  assign q_push       = accept && (n != 2'd0);
  assign q_data.cnt   = n;
  assign q_data.bytes = bytes;
  assign q_data.bare  = bare;
  assign q_data.last  = in_end_of_value;

  assign stat.phase      = phase_r;
  assign stat.query_seen = query_r;

  // Escape state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= upd_pkg::PH_IDLE;
      held_r  <= 8'd0;
      query_r <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      query_r <= query_nxt;
    end
  end

endmodule

### rtl/upd_fifo.sv
`timescale 1ns / 1ps

module upd_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  upd_pkg::bundle_t wr_data,
  output logic             full,
  input  logic             rd_en,
  output upd_pkg::bundle_t rd_data,
  output logic             not_empty,
  output logic [upd_pkg::FIFO_AW:0] level
);

  upd_pkg::bundle_t             mem_r [upd_pkg::FIFO_DEPTH];
  logic [upd_pkg::FIFO_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [upd_pkg::FIFO_AW:0]    cnt_r, cnt_nxt;
  logic                         do_wr, do_rd;

  assign full      = (cnt_r == upd_pkg::FIFO_DEPTH[upd_pkg::FIFO_AW:0]);
  assign not_empty = (cnt_r != '0);
  assign do_wr     = wr_en && !full;
  assign do_rd     = rd_en && not_empty;
  assign rd_data   = mem_r[rd_ptr_r];
  assign level     = cnt_r;

  // Occupancy follows the write and read requests.
  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### rtl/upd_back.sv
`timescale 1ns / 1ps

module upd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  upd_pkg::bundle_t q_data,
  input  logic             q_not_empty,
  output logic             q_pop,
  input  logic             pop,
  output logic             empty,
  output logic [7:0]       out_out_byte,
  output logic             out_byte_valid,
  output logic             out_last_of_value
);

  logic       vld_r, vld_nxt;
  logic [1:0] idx_r;
  logic [7:0] byte_r;
  logic       bvld_r;
  logic       last_r;
  logic       take;
  logic       final_slot;

  // Load the next slot when the output register is free or being taken.
  assign take       = q_not_empty && (!vld_r || pop);
  assign final_slot = (idx_r == (q_data.cnt - 2'd1));
  assign q_pop      = take && final_slot;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (pop) begin
      vld_nxt = 1'b0;
    end
  end

  // Slot counter and valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 2'd0;
    end else begin
      vld_r <= vld_nxt;
      if (take) begin
        idx_r <= final_slot ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= q_data.bytes[idx_r];
      bvld_r <= !q_data.bare;
      last_r <= q_data.last && final_slot;
    end
  end

  assign empty             = !vld_r;
  assign out_out_byte      = byte_r;
  assign out_byte_valid    = bvld_r;
  assign out_last_of_value = last_r;

endmodule

### rtl/uri_percent_decoder.sv
`timescale 1ns / 1ps
`include "uri_percent_decoder_macros.svh"

// Streaming percent-decoder for request header values. Bytes enter one per
// clock through push/full with in_end_of_value on the final byte; results
// leave through empty/pop, one per clock, with out_last_of_value on the final
// result of each value (a value whose last byte yields nothing closes with a
// bare marker, out_byte_valid low). An accepted byte passes through the queue
// and then the output register before its first result is on the output
// ports. A byte yields up to three results, and the output register drains
// one result per clock while pop is held, so sustained input is one byte per
// clock while each byte yields at most one result; bytes that yield two or
// three results take one output slot for each result.
// A four-entry queue between the classifier and the output stage absorbs
// bursts, and full rises only when that queue is full.
module uri_percent_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_value_byte,
  input  logic       in_end_of_value,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_out_byte,
  output logic       out_byte_valid,
  output logic       out_last_of_value
);

  upd_pkg::bundle_t     f_data, b_data;
  upd_pkg::front_stat_t f_stat;
  logic                 f_push;
  logic                 q_full;
  logic                 q_not_empty;
  logic                 q_pop;
  logic [upd_pkg::FIFO_AW:0] q_level;

  assign full = q_full;

  // Classifier and escape state.
  upd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (push),
    .in_value_byte   (in_value_byte),
    .in_end_of_value (in_end_of_value),
    .q_full          (q_full),
    .q_push          (f_push),
    .q_data          (f_data),
    .stat            (f_stat)
  );

  // Result queue between the two halves.
  upd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (f_push),
    .wr_data   (f_data),
    .full      (q_full),
    .rd_en     (q_pop),
    .rd_data   (b_data),
    .not_empty (q_not_empty),
    .level     (q_level)
  );

  // Serializer and output register.
  upd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_data            (b_data),
    .q_not_empty       (q_not_empty),
    .q_pop             (q_pop),
    .pop               (pop),
    .empty             (empty),
    .out_out_byte      (out_out_byte),
    .out_byte_valid    (out_byte_valid),
    .out_last_of_value (out_last_of_value)
  );

  // Checks on the decoder's own logic.
  `UPD_ASSERT_NOW(a_queue_bound, 1'b1, q_level <= upd_pkg::FIFO_DEPTH[upd_pkg::FIFO_AW:0], "queue level above depth")
  `UPD_ASSERT_NOW(a_bare_is_last, !empty && !out_byte_valid, out_last_of_value, "bare marker not last")
  `UPD_ASSERT_NOW(a_bundle_nonempty, q_not_empty, b_data.cnt != 2'd0, "queued request with no result")
  `UPD_ASSERT_NEXT(a_state_cleared, push && !full && in_end_of_value, f_stat.phase == upd_pkg::PH_IDLE && !f_stat.query_seen, "state not cleared after value end")

endmodule
